// ===== hdl/zst_pkg.sv =====
`default_nettype none

package zst_pkg;

  // pixel classification and neighbor-count limits
  localparam logic [7:0] WHITE_BYTE = 8'hFF;
  localparam logic [3:0] MIN_NBR    = 4'd2;
  localparam logic [3:0] MAX_NBR    = 4'd6;

  // field widths fixed by the stream format
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int TALLY_W    = 20;
  localparam int CFG_DATA_W = 11;

  // result buffer between the pipeline and the output port
  localparam int OUT_FIFO_DEPTH = 4;

  // configuration register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SUB_PASS   = 2'd0;
  localparam reg_idx_t REG_FRAME_ROWS = 2'd1;
  localparam reg_idx_t REG_FRAME_COLS = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [PIX_W-1:0]   out_pixel;
    logic               was_removed;
    logic [TALLY_W-1:0] removed_so_far;
    logic               frame_last;
  } out_item_t;

  typedef struct packed {
    reg_idx_t              reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  // window stage handed from the front end to the decision stage
  typedef struct packed {
    logic               vld;
    logic               emit;
    logic               frame_end;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [8:0]         white;   // 3x3 white flags, index row*3+col
    logic [PIX_W-1:0]   center;
  } win_t;

  // Zhang-Suen removal test on the 3x3 white flags
  function automatic logic zs_remove(input logic [8:0] white, input logic sub_pass);
    logic [7:0] n;
    logic [3:0] cnt;
    logic [3:0] trans;
    logic       prod_ok;
    // ring P2..P9 clockwise from the top
    n = {white[0], white[3], white[6], white[7], white[8], white[5], white[2], white[1]};
    cnt   = '0;
    trans = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + {3'b000, n[i]};
      if (!n[i] && n[(i + 1) & 7]) begin
        trans = trans + 4'd1;
      end
    end
    if (!sub_pass) begin
      prod_ok = !(n[0] & n[2] & n[4]) && !(n[2] & n[4] & n[6]);
    end else begin
      prod_ok = !(n[0] & n[2] & n[6]) && !(n[0] & n[4] & n[6]);
    end
    return white[4] && (cnt >= MIN_NBR) && (cnt <= MAX_NBR) && (trans == 4'd1) && prod_ok;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/zst_chan_if.sv =====
`default_nettype none

// valid/ready channel carrying one request of type T
interface zst_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/zst_ram.sv =====
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module zst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/zst_front.sv =====
`default_nettype none

// raster position, two line stores in one RAM, and the 3x3 window
module zst_front #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          acc,
  input  wire logic [7:0]                    px,
  input  wire logic [$clog2(MAX_ROWS)-1:0]   last_row,
  input  wire logic [$clog2(MAX_COLS)-1:0]   last_col,
  output logic                               a_vld,
  output zst_pkg::win_t                      win
);
  import zst_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  // position of the next request
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          row_end, frame_end, emit;
  logic [RW-1:0] row_m1;
  logic [CW-1:0] col_m1;
  logic [RW+COORD_W-1:0] row_ext;
  logic [CW+COORD_W-1:0] col_ext;

  // stage A: request registered while the line stores are read
  logic               a_vld_r;
  logic [PIX_W-1:0]   a_px_r;
  logic [CW-1:0]      a_addr_r;
  logic               a_emit_r;
  logic               a_frame_end_r;
  logic [COORD_W-1:0] a_row_r;
  logic [COORD_W-1:0] a_col_r;

  // window stage
  logic               w_vld_r;
  logic               w_emit_r;
  logic               w_frame_end_r;
  logic [COORD_W-1:0] w_row_r;
  logic [COORD_W-1:0] w_col_r;
  logic [8:0]         white_r;
  logic [PIX_W-1:0]   center_r;
  logic [PIX_W-1:0]   right_mid_r;

  // line store: {older, prev} per column
  logic [2*PIX_W-1:0] ls_rdata;
  logic [PIX_W-1:0]   top_px, mid_px;

  assign row_end   = (col_r >= last_col);
  assign frame_end = row_end && (row_r >= last_row);
  assign emit      = (row_r >= RW'(2)) && (col_r >= CW'(2));
  assign row_m1    = row_r - RW'(1);
  assign col_m1    = col_r - CW'(1);
  assign row_ext   = {{COORD_W{1'b0}}, row_m1};
  assign col_ext   = {{COORD_W{1'b0}}, col_m1};

  // position advance
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_px_r        <= px;
      a_addr_r      <= col_r;
      a_emit_r      <= emit;
      a_frame_end_r <= frame_end;
      a_row_r       <= row_ext[COORD_W-1:0];
      a_col_r       <= col_ext[COORD_W-1:0];
    end
  end

  // read on accept, rotate the column in the following cycle
  zst_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (a_vld_r),
    .waddr (a_addr_r),
    .wdata ({mid_px, a_px_r}),
    .re    (acc),
    .raddr (col_r),
    .rdata (ls_rdata)
  );

  assign top_px = ls_rdata[2*PIX_W-1:PIX_W];
  assign mid_px = ls_rdata[PIX_W-1:0];

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_vld_r <= 1'b0;
    end else begin
      w_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld_r) begin
      white_r       <= {a_px_r == WHITE_BYTE, white_r[8:7],
                        mid_px == WHITE_BYTE, white_r[5:4],
                        top_px == WHITE_BYTE, white_r[2:1]};
      center_r      <= right_mid_r;
      right_mid_r   <= mid_px;
      w_emit_r      <= a_emit_r;
      w_frame_end_r <= a_frame_end_r;
      w_row_r       <= a_row_r;
      w_col_r       <= a_col_r;
    end
  end

  assign a_vld          = a_vld_r;
  assign win.vld        = w_vld_r;
  assign win.emit       = w_emit_r;
  assign win.frame_end  = w_frame_end_r;
  assign win.row        = w_row_r;
  assign win.col        = w_col_r;
  assign win.white      = white_r;
  assign win.center     = center_r;

  // the request that ends a frame sends the scan back to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && frame_end) |=> (row_r == '0 && col_r == '0))
    else $error("scan position not cleared after frame end");

endmodule

`default_nettype wire

// ===== hdl/zst_decide.sv =====
`default_nettype none

// removal decision and running removal count
module zst_decide (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire zst_pkg::win_t     win,
  input  wire logic              sub_pass,
  output logic                   push,
  output zst_pkg::out_item_t     item
);
  import zst_pkg::*;

  logic [TALLY_W-1:0] tally_r, tally_nxt, tally_inc;
  logic               rem;

  assign rem       = win.emit && zs_remove(win.white, sub_pass);
  assign tally_inc = (rem && (tally_r != '1)) ? tally_r + TALLY_W'(1) : tally_r;

  // count clears after the last pixel of a frame
  always_comb begin
    tally_nxt = tally_r;
    if (win.vld) begin
      tally_nxt = win.frame_end ? '0 : tally_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
    end else begin
      tally_r <= tally_nxt;
    end
  end

  assign push                = win.vld && win.emit;
  assign item.out_row        = win.row;
  assign item.out_col        = win.col;
  assign item.out_pixel      = rem ? '0 : win.center;
  assign item.was_removed    = rem;
  assign item.removed_so_far = tally_inc;
  assign item.frame_last     = win.frame_end;

  a_tally_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (win.vld && win.frame_end) |=> (tally_r == '0))
    else $error("removal count not cleared at frame end");

  a_rem_white: assert property (@(posedge clk) disable iff (!rst_n)
    (push && item.was_removed) |-> (win.white[4] && item.out_pixel == '0))
    else $error("removed pixel was not white or not zeroed");

endmodule

`default_nettype wire

// ===== hdl/zst_fifo.sv =====
`default_nettype none

// result buffer driving the output channel
module zst_fifo (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       push,
  input  wire zst_pkg::out_item_t                         din,
  output logic [$clog2(zst_pkg::OUT_FIFO_DEPTH+1)-1:0]    cnt,
  zst_chan_if.source                                      out_res
);
  import zst_pkg::*;

  localparam int PW = $clog2(OUT_FIFO_DEPTH);
  localparam int CNTW = $clog2(OUT_FIFO_DEPTH + 1);

  out_item_t       buf_r [OUT_FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            pop;

  assign pop = out_res.valid && out_res.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= din;
    end
  end

  assign out_res.valid = (cnt_r != '0);
  assign out_res.data  = buf_r[rd_ptr_r];
  assign cnt           = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < CNTW'(OUT_FIFO_DEPTH) || pop))
    else $error("result buffer overflow");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - CNTW'(1)))
    else $error("result buffer count wrong after pop");

endmodule

`default_nettype wire

// ===== hdl/zhang_suen_thinning_pass.sv =====
`default_nettype none

// One Zhang-Suen thinning sub-iteration over a raster-order stream of grey
// bytes (white means exactly 255). A pixel is accepted every clock while
// input ready is high; the result for interior pixel (r-1,c-1) leaves after
// pixel (r,c) is taken, border pixels produce no result. The rate is set by
// the line-store RAM, read on accept and written back on the next cycle,
// and by a 4-entry result buffer: input ready drops only when that buffer
// plus the two requests in flight would overflow it. The user is to write
// sub_pass, frame_rows and frame_cols through the configuration channel
// only while the block is idle; the block does not check this. Sizes are
// clamped to 3..MAX_ROWS and 3..MAX_COLS. The removal count in each result
// clears after a frame's last pixel. No clearing pass is needed after reset.
module zhang_suen_thinning_pass #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  zst_chan_if.sink   in_req,
  zst_chan_if.source out_res,
  zst_chan_if.sink   cfg_req
);
  import zst_pkg::*;

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_COLS);
  localparam int CNTW = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int OCCW = CNTW + 1;
  localparam int LAST_ROW_RST = (MAX_ROWS < 1024) ? MAX_ROWS - 1 : 1023;
  localparam int LAST_COL_RST = (MAX_COLS < 1024) ? MAX_COLS - 1 : 1023;

  // configuration, sizes kept as last index
  logic          sub_pass_r;
  logic [RW-1:0] last_row_r;
  logic [CW-1:0] last_col_r;
  logic [RW-1:0] last_row_wr;
  logic [CW-1:0] last_col_wr;
  logic          cfg_wr;
  logic [CFG_DATA_W-1:0] cfg_val;

  logic            acc;
  logic            a_vld;
  win_t            win;
  logic            push;
  out_item_t       item;
  logic [CNTW-1:0] fifo_cnt;
  logic [OCCW-1:0] occ;

  assign cfg_req.ready = 1'b1;
  assign cfg_wr        = cfg_req.valid && cfg_req.ready;
  assign cfg_val       = cfg_req.data.wdata;

  // clamp written sizes to the supported range
  always_comb begin
    if (cfg_val < CFG_DATA_W'(3)) begin
      last_row_wr = RW'(2);
    end else if (32'(cfg_val) > MAX_ROWS) begin
      last_row_wr = RW'(MAX_ROWS - 1);
    end else begin
      last_row_wr = RW'(cfg_val - CFG_DATA_W'(1));
    end
    if (cfg_val < CFG_DATA_W'(3)) begin
      last_col_wr = CW'(2);
    end else if (32'(cfg_val) > MAX_COLS) begin
      last_col_wr = CW'(MAX_COLS - 1);
    end else begin
      last_col_wr = CW'(cfg_val - CFG_DATA_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_pass_r <= 1'b0;
      last_row_r <= RW'(LAST_ROW_RST);
      last_col_r <= CW'(LAST_COL_RST);
    end else if (cfg_wr) begin
      case (cfg_req.data.reg_index)
        REG_SUB_PASS:   sub_pass_r <= cfg_val[0];
        REG_FRAME_ROWS: last_row_r <= last_row_wr;
        REG_FRAME_COLS: last_col_r <= last_col_wr;
        default: ;
      endcase
    end
  end

  // room for everything in flight plus one more request
  assign occ          = {1'b0, fifo_cnt} + {{CNTW{1'b0}}, a_vld} + {{CNTW{1'b0}}, win.vld};
  assign in_req.ready = (occ < OCCW'(OUT_FIFO_DEPTH));
  assign acc          = in_req.valid && in_req.ready;

  zst_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .px       (in_req.data.pixel_value),
    .last_row (last_row_r),
    .last_col (last_col_r),
    .a_vld    (a_vld),
    .win      (win)
  );

  zst_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .win      (win),
    .sub_pass (sub_pass_r),
    .push     (push),
    .item     (item)
  );

  zst_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .din     (item),
    .cnt     (fifo_cnt),
    .out_res (out_res)
  );

endmodule

`default_nettype wire
